// ----- rtl/qdcw_pkg.sv -----
// Shared types, constants and helpers of the queue-delay congestion window block.
package qdcw_pkg;

	// Field widths of the stream payloads
	localparam int RATE_W     = 32;
	localparam int MS_W       = 16;
	localparam int SIZE_W     = 16;
	localparam int FRAC_W     = 9;
	localparam int CNT_W      = 8;
	localparam int CFG_WIN_W  = 20;
	localparam int OUT_WIN_W  = 20;
	localparam int IN_DATA_W  = 112;
	localparam int OUT_DATA_W = 24;
	localparam int OUT_USER_W = 2;
	localparam int CFG_DATA_W = 20;
	localparam int CFG_IDX_W  = 3;

	// Shared multiplier operand and product widths
	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 16;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// Divider widths: rate*rtt + den - 1, and size*1000
	localparam int DIVIDEND_W = 49;
	localparam int DIVISOR_W  = 26;

	// Milliseconds per second, scales the packet size in the window divide
	localparam logic [MUL_B_W-1:0] MS_PER_SEC = 16'd1000;

	// Register reset values
	localparam logic                 ENABLE_RST     = 1'b1;
	localparam logic [FRAC_W-1:0]    TARGET_FRAC_RST = 9'd204;
	localparam logic [MS_W-1:0]      MAX_QDELAY_RST = 16'd20;
	localparam logic [CNT_W-1:0]     ROUNDS_RST     = 8'd3;
	localparam logic [FRAC_W-1:0]    DEC_FACTOR_RST = 9'd205;
	localparam logic [FRAC_W-1:0]    INC_FACTOR_RST = 9'd281;
	localparam logic [CFG_WIN_W-1:0] MIN_WINDOW_RST = 20'd5;
	localparam logic [CFG_WIN_W-1:0] MAX_WINDOW_RST = 20'd100000;

	// Register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENABLE       = 3'd0,
		CFG_TARGET_FRAC  = 3'd1,
		CFG_MAX_QDELAY   = 3'd2,
		CFG_ROUNDS       = 3'd3,
		CFG_DEC_FACTOR   = 3'd4,
		CFG_INC_FACTOR   = 3'd5,
		CFG_MIN_WINDOW   = 3'd6,
		CFG_MAX_WINDOW   = 3'd7
	} cfg_reg_t;

	// Divide request from the sequencer
	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [DIVISOR_W-1:0]  divisor;
	} div_req_t;

	// Round counter increment, saturating at all ones
	function automatic logic [CNT_W-1:0] inc8(input logic [CNT_W-1:0] v);
		return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
	endfunction

endpackage

// ----- rtl/queue_delay_congestion_window_top.sv -----
// Queue-delay congestion window controller: registers, sequencer and stream ports.
//
// One input transaction on s_* carries a round of measurements (received rate,
// producer rate, minimum RTT, average packet size, queuing delay). The block
// classifies the round as normal or congested, updates its window state and
// returns one result transaction on m_*: the window in m_tdata and the
// congested and updated flags in m_tuser.
// Configuration registers are written through cfg_we/cfg_index/cfg_data; the
// user must write them only while no round is in flight, which the block
// does not enforce. A write takes effect at the next clock edge. A skipped
// round (enable low or zero RTT) skips classification; a classified round
// may also scale the window; a round entering congestion forms its initial
// window in the bit-serial divider, which finishes at once when that window
// saturates. All products go through one shared multiplier. s_tready is
// high only while the sequencer is idle, so one round is in flight at a time.
// A finished result sits in the output register until m_tready; the next
// round may be accepted meanwhile and waits at its end for that register.
// Reset (arst_n low) loads the register defaults, clears the round state and
// sets the window to max_window saturated to WINDOW_BITS.
module queue_delay_congestion_window_top
	import qdcw_pkg::*;
#(
	parameter int WINDOW_BITS = 20
)
(
	input  logic                  clk,
	input  logic                  arst_n,
	// s_tdata, from bit 0: rx_rate[31:0], producer_rate[31:0],
	// min_rtt_ms[15:0], avg_packet_size[15:0], queuing_delay_ms[15:0]
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// m_tdata, from bit 0: window[19:0], 4 zero bits
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	// m_tuser, from bit 0: congested, updated
	output logic [OUT_USER_W-1:0] m_tuser,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int SAT_W = 34;
	localparam logic [SAT_W-1:0] WIN_LIMIT = (SAT_W'(1) << WINDOW_BITS) - SAT_W'(1);

	function automatic logic [WINDOW_BITS-1:0] sat_win(input logic [SAT_W-1:0] v);
		return (v > WIN_LIMIT) ? WIN_LIMIT[WINDOW_BITS-1:0] : v[WINDOW_BITS-1:0];
	endfunction

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_CLASSIFY,
		ST_NUM,
		ST_DEN,
		ST_DIV_SETUP,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_CHK_DEC,
		ST_SCALE,
		ST_APPLY,
		ST_FINISH
	} state_t;

	// Configuration registers
	logic                 enable_q;
	logic [FRAC_W-1:0]    target_frac_q;
	logic [MS_W-1:0]      max_qdelay_q;
	logic [CNT_W-1:0]     rounds_q;
	logic [FRAC_W-1:0]    dec_factor_q;
	logic [FRAC_W-1:0]    inc_factor_q;
	logic [CFG_WIN_W-1:0] min_window_q;
	logic [CFG_WIN_W-1:0] max_window_q;

	// Round state
	state_t                 state_q;
	logic                   congested_q;
	logic [MS_W-1:0]        prev_qdelay_q;
	logic [CNT_W-1:0]       since_drop_q;
	logic [CNT_W-1:0]       no_cong_q;
	logic [WINDOW_BITS-1:0] window_q;
	logic                   dec_mode_q;
	logic                   updated_q;

	// Captured measurements and intermediates
	logic [RATE_W-1:0]     rx_q;
	logic [RATE_W-1:0]     prod_q;
	logic [MS_W-1:0]       rtt_q;
	logic [SIZE_W-1:0]     size_q;
	logic [MS_W-1:0]       qdelay_q;
	logic [MUL_P_W-1:0]    num_q;
	logic [DIVIDEND_W-1:0] dividend_q;
	logic [DIVISOR_W-1:0]  den_q;

	// Output register
	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic [OUT_USER_W-1:0] m_tuser_q;

	// Shared units
	logic [MUL_A_W-1:0]     mul_a;
	logic [MUL_B_W-1:0]     mul_b;
	logic [MUL_P_W-1:0]     product;
	div_req_t               div_req;
	logic                   div_done;
	logic [WINDOW_BITS-1:0] div_quotient;

	// Decision logic
	logic                   target_met;
	logic                   now_congested;
	logic [CNT_W-1:0]       no_cong_next;
	logic [SIZE_W-1:0]      size_eff;
	logic [WINDOW_BITS-1:0] scaled_w;
	logic [WINDOW_BITS-1:0] floor_w;
	logic [WINDOW_BITS-1:0] cap_w;
	logic [SAT_W-1:0]       win_ext;
	logic                   out_free;

	qdcw_mul u_mul (
		.clk     (clk),
		.a       (mul_a),
		.b       (mul_b),
		.product (product)
	);

	qdcw_div #(
		.QW (WINDOW_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quotient)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q      <= ENABLE_RST;
			target_frac_q <= TARGET_FRAC_RST;
			max_qdelay_q  <= MAX_QDELAY_RST;
			rounds_q      <= ROUNDS_RST;
			dec_factor_q  <= DEC_FACTOR_RST;
			inc_factor_q  <= INC_FACTOR_RST;
			min_window_q  <= MIN_WINDOW_RST;
			max_window_q  <= MAX_WINDOW_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ENABLE:      enable_q      <= cfg_data[0];
				CFG_TARGET_FRAC: target_frac_q <= cfg_data[FRAC_W-1:0];
				CFG_MAX_QDELAY:  max_qdelay_q  <= cfg_data[MS_W-1:0];
				CFG_ROUNDS:      rounds_q      <= cfg_data[CNT_W-1:0];
				CFG_DEC_FACTOR:  dec_factor_q  <= cfg_data[FRAC_W-1:0];
				CFG_INC_FACTOR:  inc_factor_q  <= cfg_data[FRAC_W-1:0];
				CFG_MIN_WINDOW:  min_window_q  <= cfg_data[CFG_WIN_W-1:0];
				CFG_MAX_WINDOW:  max_window_q  <= cfg_data[CFG_WIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Select multiplier operands by sequencer step
	assign size_eff = (size_q == '0) ? SIZE_W'(1) : size_q;

	always_comb begin
		case (state_q)
			ST_START: begin
				mul_a = prod_q;
				mul_b = MUL_B_W'(target_frac_q);
			end
			ST_NUM: begin
				mul_a = rx_q;
				mul_b = rtt_q;
			end
			ST_DEN: begin
				mul_a = MUL_A_W'(size_eff);
				mul_b = MS_PER_SEC;
			end
			ST_SCALE: begin
				mul_a = MUL_A_W'(window_q);
				mul_b = MUL_B_W'(dec_mode_q ? dec_factor_q : inc_factor_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Classify: target test while not congested, then delay limit or stuck delay
	assign target_met    = {1'b0, rx_q, 8'b0} >= product[RATE_W+FRAC_W-1:0];
	assign now_congested = (!congested_q && target_met) ? 1'b0 :
		((qdelay_q > max_qdelay_q) || (prev_qdelay_q == qdelay_q));
	assign no_cong_next  = congested_q ? CNT_W'(1) : inc8(no_cong_q);

	// Scale the window by a Q1.8 decrease or Q1.8 increase factor, then floor or cap
	assign scaled_w = sat_win(SAT_W'(product[RATE_W+FRAC_W-1:8]));
	assign floor_w  = sat_win(SAT_W'(min_window_q));
	assign cap_w    = sat_win(SAT_W'(max_window_q));

	// Start the divide with the registered dividend and divisor
	always_comb begin
		div_req.start    = (state_q == ST_DIV_GO);
		div_req.dividend = dividend_q;
		div_req.divisor  = den_q;
	end

	assign win_ext  = SAT_W'(window_q);
	assign out_free = !m_tvalid_q || m_tready;

	// Sequencer, round state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			congested_q   <= 1'b0;
			prev_qdelay_q <= '0;
			since_drop_q  <= '0;
			no_cong_q     <= '0;
			window_q      <= sat_win(SAT_W'(MAX_WINDOW_RST));
			dec_mode_q    <= 1'b0;
			updated_q     <= 1'b0;
			rx_q          <= '0;
			prod_q        <= '0;
			rtt_q         <= '0;
			size_q        <= '0;
			qdelay_q      <= '0;
			num_q         <= '0;
			dividend_q    <= '0;
			den_q         <= '0;
			m_tvalid_q    <= 1'b0;
			m_tdata_q     <= '0;
			m_tuser_q     <= '0;
		end else begin
			// Drop the result once the receiver takes it and no new one loads
			if (m_tvalid_q && m_tready && !(state_q == ST_FINISH && out_free))
				m_tvalid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						rx_q     <= s_tdata[31:0];
						prod_q   <= s_tdata[63:32];
						rtt_q    <= s_tdata[79:64];
						size_q   <= s_tdata[95:80];
						qdelay_q <= s_tdata[111:96];
						state_q  <= ST_START;
					end
				end
				ST_START: begin
					if (!enable_q || rtt_q == '0) begin
						updated_q <= 1'b0;
						state_q   <= ST_FINISH;
					end else begin
						updated_q <= 1'b1;
						state_q   <= ST_CLASSIFY;
					end
				end
				ST_CLASSIFY: begin
					congested_q   <= now_congested;
					prev_qdelay_q <= qdelay_q;
					if (now_congested && !congested_q) begin
						state_q <= ST_NUM;
					end else if (now_congested) begin
						state_q <= ST_CHK_DEC;
					end else begin
						no_cong_q <= no_cong_next;
						if (no_cong_next >= rounds_q) begin
							dec_mode_q <= 1'b0;
							state_q    <= ST_SCALE;
						end else begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_NUM: begin
					state_q <= ST_DEN;
				end
				ST_DEN: begin
					num_q   <= product;
					state_q <= ST_DIV_SETUP;
				end
				ST_DIV_SETUP: begin
					// Round up: (num + den - 1) / den
					den_q      <= product[DIVISOR_W-1:0];
					dividend_q <= DIVIDEND_W'(num_q) + DIVIDEND_W'(product[DIVISOR_W-1:0])
						- DIVIDEND_W'(1);
					state_q    <= ST_DIV_GO;
				end
				ST_DIV_GO: begin
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (div_done) begin
						window_q     <= div_quotient;
						since_drop_q <= inc8(rounds_q);
						state_q      <= ST_CHK_DEC;
					end
				end
				ST_CHK_DEC: begin
					if (since_drop_q >= rounds_q) begin
						dec_mode_q <= 1'b1;
						state_q    <= ST_SCALE;
					end else begin
						since_drop_q <= inc8(since_drop_q);
						state_q      <= ST_FINISH;
					end
				end
				ST_SCALE: begin
					state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					if (dec_mode_q) begin
						window_q     <= (scaled_w < floor_w) ? floor_w : scaled_w;
						since_drop_q <= '0;
					end else begin
						window_q <= (scaled_w > cap_w) ? cap_w : scaled_w;
					end
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					// Hold until the output register is free
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {{(OUT_DATA_W-OUT_WIN_W){1'b0}}, win_ext[OUT_WIN_W-1:0]};
						m_tuser_q  <= {updated_q, congested_q};
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// ----- rtl/qdcw_mul.sv -----
// Shared multiplier with a registered product.
module qdcw_mul
	import qdcw_pkg::*;
(
	input  logic               clk,
	input  logic [MUL_A_W-1:0] a,
	input  logic [MUL_B_W-1:0] b,
	output logic [MUL_P_W-1:0] product
);

	logic [MUL_P_W-1:0] product_q;

	// Register the product every cycle; the sequencer reads it in the next state
	always_ff @(posedge clk) begin
		product_q <= MUL_P_W'(a) * MUL_P_W'(b);
	end

	assign product = product_q;

endmodule

// ----- rtl/qdcw_div.sv -----
// Iterative restoring divider, one quotient bit per cycle, quotient saturated.
module qdcw_div
	import qdcw_pkg::*;
#(
	parameter int QW = 20
)
(
	input  logic          clk,
	input  logic          arst_n,
	input  div_req_t      req,
	output logic          done,
	output logic [QW-1:0] quotient
);

	localparam int CW = $clog2(QW);
	localparam logic [CW-1:0] LAST_STEP = CW'(QW - 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CW-1:0]         step_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  den_q;
	logic [QW-1:0]         low_q;

	logic [DIVIDEND_W-1:0] high_part;
	logic                  overflow;
	logic [DIVISOR_W:0]    rem_shift;
	logic [DIVISOR_W:0]    rem_diff;
	logic                  fits;

	// Quotient would not fit in QW bits when the high part reaches the divisor
	assign high_part = req.dividend >> QW;
	assign overflow  = high_part >= DIVIDEND_W'(req.divisor);

	// One restoring step: shift in the next dividend bit, subtract when it fits
	assign rem_shift = {rem_q, low_q[QW-1]};
	assign rem_diff  = rem_shift - {1'b0, den_q};
	assign fits      = rem_shift >= {1'b0, den_q};

	// Control: start, count steps, pulse done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				step_q <= '0;
				busy_q <= !overflow;
				done_q <= overflow;
			end else if (busy_q) begin
				step_q <= step_q + CW'(1);
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: remainder, divisor and the dividend/quotient shift register
	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q <= req.divisor;
			rem_q <= high_part[DIVISOR_W-1:0];
			low_q <= overflow ? {QW{1'b1}} : req.dividend[QW-1:0];
		end else if (busy_q) begin
			rem_q <= fits ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
			low_q <= {low_q[QW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = low_q;

endmodule

// ----- rtl/qdcw_checker.sv -----
// Port-level checks of the queue-delay congestion window block, bound to the top level.
module qdcw_checker
	import qdcw_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic [OUT_USER_W-1:0] m_tuser
);

	// Hold a stalled result and its payload
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed or dropped while stalled");

	// Stay busy after taking a round
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
		else $error("input accepted again too early");

	// A new result appears only as the sequencer returns to idle
	a_result_at_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready)
		else $error("result raised while still busy");

	// Keep the padding above the window at zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_DATA_W-1:OUT_WIN_W] == '0)
		else $error("nonzero padding in result data");

endmodule

bind queue_delay_congestion_window_top qdcw_checker u_qdcw_checker (.*);

// ----- sim/testbench.sv -----
// Self-checking testbench for the queue-delay congestion window controller.
`timescale 1ns / 100ps

module testbench;
	import qdcw_pkg::*;

	localparam int          WIN_W        = 20;
	localparam logic [63:0] WIN_MAX      = (64'd1 << WIN_W) - 64'd1;
	localparam int          SILENT_LIMIT = 3000;
	localparam int          PRESSURE_LEN = 400;

	// One round of measurements as carried on s_tdata
	typedef struct packed {
		logic [MS_W-1:0]   qdelay_ms;
		logic [SIZE_W-1:0] pkt_size;
		logic [MS_W-1:0]   rtt_ms;
		logic [RATE_W-1:0] prod_rate;
		logic [RATE_W-1:0] rx_rate;
	} round_t;

	// Expected window and flags of one round
	typedef struct {
		logic [OUT_WIN_W-1:0] window;
		logic                 congested;
		logic                 updated;
	} window_result_t;

	typedef enum {MODE_NORMAL, MODE_CONGEST, MODE_NOISE} traffic_mode_t;

	// Window state tracker and result checker
	class cwnd_scoreboard;
		logic                 enable;
		logic [FRAC_W-1:0]    target_frac;
		logic [MS_W-1:0]      max_qdelay;
		logic [CNT_W-1:0]     rounds_cfg;
		logic [FRAC_W-1:0]    dec_factor;
		logic [FRAC_W-1:0]    inc_factor;
		logic [CFG_WIN_W-1:0] min_win;
		logic [CFG_WIN_W-1:0] max_win;

		logic                 congested;
		logic [MS_W-1:0]      prev_qdelay;
		logic [CNT_W-1:0]     since_drop;
		logic [CNT_W-1:0]     normal_rounds;
		logic [WIN_W-1:0]     window;

		window_result_t expected_windows[$];
		int             errors;
		int             n_checked;

		function new();
			enable        = ENABLE_RST;
			target_frac   = TARGET_FRAC_RST;
			max_qdelay    = MAX_QDELAY_RST;
			rounds_cfg    = ROUNDS_RST;
			dec_factor    = DEC_FACTOR_RST;
			inc_factor    = INC_FACTOR_RST;
			min_win       = MIN_WINDOW_RST;
			max_win       = MAX_WINDOW_RST;
			congested     = 1'b0;
			prev_qdelay   = '0;
			since_drop    = '0;
			normal_rounds = '0;
			window        = clamp_win(64'(MAX_WINDOW_RST));
			errors        = 0;
			n_checked     = 0;
		endfunction

		function logic [WIN_W-1:0] clamp_win(logic [63:0] v);
			return (v > WIN_MAX) ? WIN_MAX[WIN_W-1:0] : v[WIN_W-1:0];
		endfunction

		function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
			return (&v) ? v : v + 1'b1;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_ENABLE:      enable      = val[0];
				CFG_TARGET_FRAC: target_frac = val[FRAC_W-1:0];
				CFG_MAX_QDELAY:  max_qdelay  = val[MS_W-1:0];
				CFG_ROUNDS:      rounds_cfg  = val[CNT_W-1:0];
				CFG_DEC_FACTOR:  dec_factor  = val[FRAC_W-1:0];
				CFG_INC_FACTOR:  inc_factor  = val[FRAC_W-1:0];
				CFG_MIN_WINDOW:  min_win     = val[CFG_WIN_W-1:0];
				CFG_MAX_WINDOW:  max_win     = val[CFG_WIN_W-1:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_windows.size();
		endfunction

		// Advance the window state by one accepted round and queue its result
		function void note_round(round_t r);
			window_result_t res;
			logic           was_cong;
			logic           now_cong;
			logic [63:0]    num;
			logic [63:0]    den;
			logic [WIN_W-1:0] w;
			logic [WIN_W-1:0] bound;
			res.updated = 1'b0;
			if (enable && r.rtt_ms != '0) begin
				res.updated = 1'b1;
				was_cong = congested;
				if (!was_cong && (64'(r.rx_rate) << 8) >= 64'(r.prod_rate) * 64'(target_frac))
					now_cong = 1'b0;
				else if (r.qdelay_ms > max_qdelay || r.qdelay_ms == prev_qdelay)
					now_cong = 1'b1;
				else
					now_cong = 1'b0;
				congested   = now_cong;
				prev_qdelay = r.qdelay_ms;
				if (now_cong) begin
					// entering congestion: window from rate times RTT over packet bytes
					if (!was_cong) begin
						den = 64'((r.pkt_size == '0) ? 16'd1 : r.pkt_size) * 64'd1000;
						num = 64'(r.rx_rate) * 64'(r.rtt_ms);
						window = clamp_win((num + den - 64'd1) / den);
						since_drop = bump(rounds_cfg);
					end
					if (since_drop >= rounds_cfg) begin
						w = clamp_win((64'(window) * 64'(dec_factor)) >> 8);
						bound = clamp_win(64'(min_win));
						window = (w < bound) ? bound : w;
						since_drop = '0;
					end else begin
						since_drop = bump(since_drop);
					end
				end else begin
					if (was_cong)
						normal_rounds = '0;
					normal_rounds = bump(normal_rounds);
					if (normal_rounds >= rounds_cfg) begin
						w = clamp_win((64'(window) * 64'(inc_factor)) >> 8);
						bound = clamp_win(64'(max_win));
						window = (w > bound) ? bound : w;
					end
				end
			end
			res.window    = window[OUT_WIN_W-1:0];
			res.congested = congested;
			expected_windows.push_back(res);
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 40)
				$display("mismatch at result %0d: %s", n_checked, msg);
		endtask

		// Compare one accepted result against the oldest expected window
		task check_result(logic [OUT_DATA_W-1:0] data, logic [OUT_USER_W-1:0] user);
			window_result_t e;
			if (expected_windows.size() == 0) begin
				report($sformatf("unexpected result window=%0d user=%b", data[OUT_WIN_W-1:0], user));
				return;
			end
			e = expected_windows.pop_front();
			if (data[OUT_WIN_W-1:0] !== e.window)
				report($sformatf("window %0d, expected %0d", data[OUT_WIN_W-1:0], e.window));
			if (user[0] !== e.congested)
				report($sformatf("congested %b, expected %b", user[0], e.congested));
			if (user[1] !== e.updated)
				report($sformatf("updated %b, expected %b", user[1], e.updated));
			if (data[OUT_DATA_W-1:OUT_WIN_W] !== '0)
				report($sformatf("pad bits %b not zero", data[OUT_DATA_W-1:OUT_WIN_W]));
			n_checked++;
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [OUT_USER_W-1:0] m_tuser;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	cwnd_scoreboard sb = new();
	bit             idle_on = 1'b0;
	int             stall_request = 0;
	int             silent_cycles = 0;

	queue_delay_congestion_window_top #(.WINDOW_BITS(WIN_W)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one
	function automatic int gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
	endfunction

	function automatic logic [31:0] pick(int unsigned lo, int unsigned hi,
			int unsigned mid_lo, int unsigned mid_hi);
		case ($urandom_range(0, 7))
			0:       return lo;
			1:       return hi;
			default: return $urandom_range(mid_lo, mid_hi);
		endcase
	endfunction

	function automatic logic [RATE_W-1:0] sat_rate(logic [63:0] v);
		return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[RATE_W-1:0];
	endfunction

	// Build one round: normal traffic meets the target, congested traffic misses it
	function automatic round_t make_round(traffic_mode_t m);
		round_t      r;
		logic [63:0] target;
		int unsigned qlim;
		int unsigned frac;
		qlim = 32'(sb.max_qdelay);
		frac = 32'(sb.target_frac);
		r.prod_rate = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(10_000, 40_000_000);
		case ($urandom_range(0, 23))
			0:       r.rtt_ms = '0;
			1:       r.rtt_ms = 16'hFFFF;
			2:       r.rtt_ms = MS_W'($urandom);
			default: r.rtt_ms = MS_W'($urandom_range(1, 300));
		endcase
		case ($urandom_range(0, 15))
			0:       r.pkt_size = '0;
			1:       r.pkt_size = 16'hFFFF;
			2:       r.pkt_size = SIZE_W'($urandom);
			default: r.pkt_size = SIZE_W'($urandom_range(64, 1500));
		endcase
		case (m)
			MODE_NORMAL: begin
				target = ((64'(r.prod_rate) * 64'(frac)) >> 8) + 64'($urandom_range(1, 1000));
				r.rx_rate = sat_rate(target);
				r.qdelay_ms = MS_W'($urandom_range(0, qlim));
			end
			MODE_CONGEST: begin
				target = (64'(r.prod_rate) * 64'($urandom_range(0, (frac == 0) ? 0 : frac - 1))) >> 8;
				r.rx_rate = sat_rate(target);
				if ($urandom_range(0, 1) == 0 || qlim == 65535)
					r.qdelay_ms = sb.prev_qdelay;
				else
					r.qdelay_ms = MS_W'($urandom_range(qlim + 1,
						(qlim > 65335) ? 65535 : qlim + 200));
			end
			default: begin
				r.rx_rate   = $urandom;
				r.prod_rate = $urandom;
				r.qdelay_ms = MS_W'($urandom);
			end
		endcase
		return r;
	endfunction

	// Offer one round after an optional gap; valid stays high on return
	task automatic send_round(round_t r, int gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {r.qdelay_ms, r.pkt_size, r.rtt_ms, r.prod_rate, r.rx_rate};
		do @(posedge clk); while (s_tready !== 1'b1);
		sb.note_round(r);
		@(negedge clk);
	endtask

	// Write one register; the caller lowers cfg_we after the last write
	task automatic cfg_write(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
		@(negedge clk);
	endtask

	task automatic program_regs(logic en, int unsigned frac, int unsigned maxq,
			int unsigned rounds, int unsigned dec, int unsigned inc,
			int unsigned minw, int unsigned maxw);
		cfg_write(CFG_ENABLE, CFG_DATA_W'(en));
		cfg_write(CFG_TARGET_FRAC, CFG_DATA_W'(frac));
		cfg_write(CFG_MAX_QDELAY, CFG_DATA_W'(maxq));
		cfg_write(CFG_ROUNDS, CFG_DATA_W'(rounds));
		cfg_write(CFG_DEC_FACTOR, CFG_DATA_W'(dec));
		cfg_write(CFG_INC_FACTOR, CFG_DATA_W'(inc));
		cfg_write(CFG_MIN_WINDOW, CFG_DATA_W'(minw));
		cfg_write(CFG_MAX_WINDOW, CFG_DATA_W'(maxw));
		cfg_we <= 1'b0;
	endtask

	// Stop offering, wait for every expected result, then let the block settle
	task automatic drain(int settle);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	// Random rounds in runs of normal and congested traffic with some noise
	task automatic run_phase(int n_rounds, bit idle);
		traffic_mode_t mode;
		int            gap;
		int            sel;
		idle_on = idle;
		mode = MODE_CONGEST;
		for (int i = 0; i < n_rounds; i++) begin
			if ($urandom_range(0, 11) == 0) begin
				sel = $urandom_range(0, 9);
				mode = (sel < 4) ? MODE_NORMAL : (sel < 8) ? MODE_CONGEST : MODE_NOISE;
			end
			gap = (idle_on && $urandom_range(0, 2) == 0) ? gap_len() : 0;
			send_round(make_round(mode), gap);
		end
		drain(4);
	endtask

	// Result side: random back-pressure plus an occasional long hold-off
	initial begin : result_sink
		int hold;
		hold = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_request != 0) begin
				hold = stall_request;
				stall_request = 0;
			end
			if (hold > 0) begin
				m_tready <= 1'b0;
				hold--;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				hold = gap_len() - 1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Check each result transaction
	always @(posedge clk) begin
		if (m_tvalid === 1'b1 && m_tready === 1'b1)
			sb.check_result(m_tdata, m_tuser);
	end

	// Watchdog: end the run when no transaction moves for too long
	always @(posedge clk) begin
		if ((s_tvalid === 1'b1 && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready === 1'b1)) begin
			silent_cycles <= 0;
		end else begin
			silent_cycles <= silent_cycles + 1;
			if (silent_cycles >= SILENT_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", SILENT_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin : stimulus
		// Defaults: fraction 204, delay limit 20, 3 rounds, window 5..100000
		static round_t opening[$] = '{
			round_t'{16'd50,    16'd1000,  16'd0,      32'd5000,     32'd1000},
			round_t'{16'd0,     16'd1,     16'd1,      32'd0,        32'd0},
			round_t'{16'd3,     16'd100,   16'd10,     32'd1280,     32'd1020},
			round_t'{16'd4,     16'd100,   16'd10,     32'd1280,     32'd1019},
			round_t'{16'd4,     16'd100,   16'd10,     32'd1280,     32'd1019},
			round_t'{16'd21,    16'd100,   16'd10,     32'd1280,     32'd1019},
			round_t'{16'd21,    16'd100,   16'd10,     32'd1280,     32'd1019},
			round_t'{16'hFFFF,  16'd100,   16'd10,     32'd1280,     32'd1019},
			round_t'{16'd10,    16'd500,   16'd20,     32'd0,        32'hFFFF_FFFF},
			round_t'{16'd11,    16'd500,   16'd20,     32'd0,        32'hFFFF_FFFF},
			round_t'{16'd12,    16'd500,   16'd20,     32'd0,        32'hFFFF_FFFF},
			round_t'{16'd13,    16'd500,   16'd20,     32'd0,        32'hFFFF_FFFF},
			round_t'{16'd30,    16'd0,     16'd100,    32'hFFFF_FFFF, 32'd1_000_000},
			round_t'{16'd0,     16'd0,     16'd100,    32'd5,        32'hFFFF_FFFF},
			round_t'{16'hFFFF,  16'd1,     16'hFFFF,   32'hFFFF_FFFF, 32'h8000_0000},
			round_t'{16'd1,     16'hFFFF,  16'hFFFF,   32'hFFFF_FFFF, 32'hFFFF_FFFF},
			round_t'{16'hFFFF,  16'hFFFF,  16'hFFFF,   32'hFFFF_FFFF, 32'hFFFF_FFFF}
		};
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_we    = 1'b0;
		cfg_index = CFG_ENABLE;
		cfg_data  = '0;
		arst_n    = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed rounds under reset settings
		foreach (opening[i])
			send_round(opening[i], 0);
		drain(4);

		// Low extremes: tiny window bounds, no rounds between changes
		program_regs(1'b1, 511, 0, 0, 0, 256, 1, 1);
		run_phase(120, 1'b1);

		// High extremes: target always met, saturating counters and window
		program_regs(1'b1, 0, 65535, 255, 511, 511, 20'hFFFFF, 20'hFFFFF);
		run_phase(300, 1'b0);

		// Rate control off: every round is skipped
		cfg_write(CFG_ENABLE, CFG_DATA_W'(1'b0));
		cfg_we <= 1'b0;
		run_phase(20, 1'b1);

		// Random settings; one phase holds the result side off for a long stretch
		for (int p = 0; p < 6; p++) begin
			program_regs(1'b1, pick(0, 511, 150, 300), pick(0, 65535, 5, 60),
				pick(0, 255, 1, 6), pick(0, 511, 128, 250), pick(0, 511, 257, 400),
				pick(0, 20'hFFFFF, 1, 50), pick(0, 20'hFFFFF, 50, 200000));
			if (p == 1)
				stall_request = PRESSURE_LEN;
			run_phase(130, (p == 1) ? 1'b0 : p[0] == 1'b0);
		end

		drain(40);
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- queue_delay_congestion_window_top.f -----
rtl/qdcw_pkg.sv
rtl/qdcw_mul.sv
rtl/qdcw_div.sv
rtl/queue_delay_congestion_window_top.sv
rtl/qdcw_checker.sv
sim/testbench.sv
